/* sv/block_read_memory_responder_top_macros.svh */
// Assertion macros for the block read memory responder.
`ifndef BLOCK_READ_MEMORY_RESPONDER_TOP_MACROS_SVH
`define BLOCK_READ_MEMORY_RESPONDER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define BRMR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brmr check failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define BRMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brmr check failed: next-cycle implication");

`else

`define BRMR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BRMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/brmr_pkg.sv */
// Package of shared constants and types for the block read memory responder.
package brmr_pkg;

    localparam int ADDR_W      = 21;
    localparam int DATA_W      = 32;
    localparam int MEM_WORDS   = 65536;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam int BLOCK_WORDS = 8;
    localparam int BLOCK_AW    = $clog2(BLOCK_WORDS);
    localparam int LAT_W       = 8;
    localparam int ORIGIN_W    = 3;
    localparam int CMD_W       = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [LAT_W-1:0]    LATENCY_RESET = LAT_W'(16);
    localparam logic [ORIGIN_W-1:0] SELF_ID       = ORIGIN_W'(4);

    // Register index, taken from the word address of the APB port.
    localparam logic [PADDR_W-3:0] REG_READ_LATENCY = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_READX = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

endpackage

/* sv/brmr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module brmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/block_read_memory_responder_top.sv */
// Top level of the block read memory responder: bus snooping main memory with burst reads.
//
// This block is the main memory on a shared snooping bus. It takes one bus beat per clock
// cycle when not stalled: a flush from a core writes its word into the 65536-word store,
// and when the memory is idle a read or read-exclusive from a core starts a burst. The burst
// waits for read_latency further beats (flush beats do not count) and then drives the eight
// words of the aligned block on the following beats, skipping core flush beats, and flags
// the last one. Every input beat produces exactly one result beat; drive is low on beats
// where the memory puts nothing on the bus, and then the address, word and last flag are
// zero. The block sustains one beat per cycle while the output is not stalled; an accepted
// beat passes through the input register and then the result register, whose word comes
// from the registered read port of the store. After reset the store is swept to zero, one
// word per cycle, and the input stalls until the sweep is complete; the latency register
// may be written over the APB port during that sweep. Flushes above the store are dropped
// and reads above it return zero.
`include "block_read_memory_responder_top_macros.svh"

module block_read_memory_responder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input bus beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [brmr_pkg::CMD_W-1:0]    i_command,
    input  logic [brmr_pkg::ORIGIN_W-1:0] i_origin,
    input  logic [brmr_pkg::ADDR_W-1:0]   i_bus_address,
    input  logic [brmr_pkg::DATA_W-1:0]   i_bus_word,
    // Result beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_drive,
    output logic [brmr_pkg::ADDR_W-1:0]   o_out_address,
    output logic [brmr_pkg::DATA_W-1:0]   o_out_word,
    output logic                          o_last_word,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brmr_pkg::PADDR_W-1:0]  paddr,
    input  logic [brmr_pkg::PDATA_W-1:0]  pwdata,
    output logic [brmr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import brmr_pkg::*;

    // Configuration.
    logic [LAT_W-1:0] r_latency;

    // Clearing sweep of the store after reset.
    logic              r_clearing;
    logic [MEM_AW-1:0] r_clr_addr;

    // Input register.
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [ORIGIN_W-1:0] r_origin;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_word;

    // Burst state.
    logic                       r_busy;
    logic [LAT_W-1:0]           r_wait;
    logic [ADDR_W-BLOCK_AW-1:0] r_base;
    logic [BLOCK_AW-1:0]        r_index;

    // Result register; the word comes from the registered read port of the store.
    logic              r_out_valid;
    logic              r_drive;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_last;
    logic              r_oob;

    logic              in_accept;
    logic              advance;
    logic              from_core;
    logic              is_flush;
    logic              is_read;
    logic              do_drive;
    logic              at_last;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_in_range;
    logic              rd_in_range;
    logic              cfg_write;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    // The input register advances into the result register whenever the latter is free or
    // being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_in_valid && !advance);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Decode of the beat held in the input register.
    assign from_core = (r_origin != SELF_ID);
    assign is_flush  = (r_cmd == CMD_FLUSH) && from_core;
    assign is_read   = ((r_cmd == CMD_READ) || (r_cmd == CMD_READX)) && from_core;
    // A core flush takes the whole beat, so the burst is frozen while it is written.
    assign do_drive  = !is_flush && r_busy && (r_wait == '0);
    assign at_last   = (r_index == BLOCK_AW'(BLOCK_WORDS - 1));
    assign rd_addr   = {r_base, r_index};

    assign wr_in_range = ({1'b0, r_addr} < (ADDR_W + 1)'(MEM_WORDS));
    assign rd_in_range = ({1'b0, rd_addr} < (ADDR_W + 1)'(MEM_WORDS));

    // Store write port: the clearing sweep owns it until the sweep is complete.
    assign ram_we    = r_clearing || (advance && is_flush && wr_in_range);
    assign ram_waddr = r_clearing ? r_clr_addr : r_addr[MEM_AW-1:0];
    assign ram_wdata = r_clearing ? '0 : r_word;

    brmr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (advance && do_drive),
        .i_raddr (rd_addr[MEM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // APB: single register at word address zero, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_READ_LATENCY)
                     ? PDATA_W'(r_latency) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latency <= LATENCY_RESET;
        end else if (cfg_write && (paddr[PADDR_W-1:2] == REG_READ_LATENCY)) begin
            r_latency <= pwdata[LAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MEM_AW'(MEM_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= t_cmd'(i_command);
            r_origin <= i_origin;
            r_addr   <= i_bus_address;
            r_word   <= i_bus_word;
        end
    end

    // Burst state, updated as each beat other than a core flush leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_wait  <= '0;
            r_base  <= '0;
            r_index <= '0;
        end else if (advance && !is_flush) begin
            if (r_busy) begin
                if (r_wait != '0) begin
                    r_wait <= r_wait - 1'b1;
                end else if (at_last) begin
                    r_busy  <= 1'b0;
                    r_index <= '0;
                end else begin
                    r_index <= r_index + 1'b1;
                end
            end else if (is_read) begin
                r_busy  <= 1'b1;
                r_wait  <= r_latency;
                r_base  <= r_addr[ADDR_W-1:BLOCK_AW];
                r_index <= '0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive    <= do_drive;
            r_out_addr <= do_drive ? rd_addr : '0;
            r_last     <= do_drive && at_last;
            r_oob      <= !rd_in_range;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_out_address = r_out_addr;
    assign o_last_word   = r_last;
    assign o_out_word    = (r_drive && !r_oob) ? ram_rdata : '0;

    // The last word of a burst always returns the memory to idle.
    `BRMR_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, advance && do_drive && at_last, !r_busy)

    // Only a driven beat can carry a non-zero address or the last-word flag.
    `BRMR_ASSERT_SAME(a_idle_no_addr, i_clk, i_rst_n, r_out_valid && !r_drive, r_out_addr == '0)
    `BRMR_ASSERT_SAME(a_idle_no_last, i_clk, i_rst_n, r_out_valid && !r_drive, !r_last)

    // No beat is taken from the bus while the store is still being swept.
    `BRMR_ASSERT_NEXT(a_no_item_in_sweep, i_clk, i_rst_n, r_clearing, !r_in_valid)

endmodule
